@@ rtl/zbe_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// zbe_pkg
// Shared constants, types and the two-of-five digit table for the POSTNET
// ZIP code encoder.
// ----------------------------------------------------------------------------
package zbe_pkg;

    localparam int ZIP_W          = 17;
    localparam int DIGITS         = 5;
    localparam int DIGIT_W        = 4;
    localparam int BCD_W          = DIGITS * DIGIT_W;
    localparam int BARS_PER_DIGIT = 5;
    localparam int BAR_W          = (DIGITS + 1) * BARS_PER_DIGIT;
    localparam int CNT_W          = $clog2(BAR_W);
    localparam int DAB_W          = BCD_W + ZIP_W;
    localparam int STAGE_ITERS    = 6;
    localparam int LAST_ITERS     = ZIP_W - 2 * STAGE_ITERS;

    localparam logic [ZIP_W-1:0] ZIP_LIMIT = ZIP_W'(99999);
    localparam logic [CNT_W-1:0] LAST_CNT  = CNT_W'(BAR_W - 1);

    typedef struct packed {
        logic             err;
        logic [BCD_W-1:0] bcd;
    } zbe_digits_t;

    typedef struct packed {
        logic             err;
        logic [BAR_W-1:0] bars;
    } zbe_bars_t;

    function automatic logic [BARS_PER_DIGIT-1:0] bar_code(input logic [DIGIT_W-1:0] d);
        logic [BARS_PER_DIGIT-1:0] c;
        unique case (d)
            4'd0:    c = 5'b11000;
            4'd1:    c = 5'b00011;
            4'd2:    c = 5'b00101;
            4'd3:    c = 5'b00110;
            4'd4:    c = 5'b01001;
            4'd5:    c = 5'b01010;
            4'd6:    c = 5'b01100;
            4'd7:    c = 5'b10001;
            4'd8:    c = 5'b10010;
            4'd9:    c = 5'b10100;
            default: c = 5'b00000;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

@@ rtl/zbe_bcd_conv.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// zbe_bcd_conv
// Three-stage shift-and-add-three converter from binary ZIP code to five BCD
// digits, with the range check carried alongside.
// ----------------------------------------------------------------------------
module zbe_bcd_conv
    import zbe_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             zip_valid,
    output logic                  zip_stall,
    input  wire logic [ZIP_W-1:0] zip_code,
    output logic                  dig_valid,
    input  wire logic             dig_stall,
    output zbe_digits_t           dig
);

    function automatic logic [DAB_W-1:0] dabble(input logic [DAB_W-1:0] v, input int n);
        logic [DAB_W-1:0] t;
        t = v;
        for (int i = 0; i < STAGE_ITERS; i++)
        begin
            if (i < n)
            begin
                for (int j = 0; j < DIGITS; j++)
                begin
                    if (t[ZIP_W + DIGIT_W*j +: DIGIT_W] >= 4'd5)
                    begin
                        t[ZIP_W + DIGIT_W*j +: DIGIT_W] =
                            t[ZIP_W + DIGIT_W*j +: DIGIT_W] + 4'd3;
                    end
                end
                t = t << 1;
            end
        end
        return t;
    endfunction

    logic                   valid_reg [3];
    logic                   err_reg   [3];
    logic [DAB_W-1:0]       val_reg   [3];
    logic [DAB_W-1:0]       val_next  [3];
    logic                   ready     [4];
    logic                   src_valid [3];
    logic                   src_err   [3];

    always_comb
    begin
        ready[3] = !dig_stall;
        for (int s = 2; s >= 0; s--)
        begin
            ready[s] = !valid_reg[s] || ready[s+1];
        end
        src_valid[0] = zip_valid;
        src_err[0]   = zip_code > ZIP_LIMIT;
        val_next[0]  = dabble({{BCD_W{1'b0}}, zip_code}, STAGE_ITERS);
        src_valid[1] = valid_reg[0];
        src_err[1]   = err_reg[0];
        val_next[1]  = dabble(val_reg[0], STAGE_ITERS);
        src_valid[2] = valid_reg[1];
        src_err[2]   = err_reg[1];
        val_next[2]  = dabble(val_reg[1], LAST_ITERS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < 3; s++)
            begin
                valid_reg[s] <= 1'b0;
            end
        end
        else
        begin
            for (int s = 0; s < 3; s++)
            begin
                if (ready[s])
                begin
                    valid_reg[s] <= src_valid[s];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < 3; s++)
        begin
            if (ready[s] && src_valid[s])
            begin
                err_reg[s] <= src_err[s];
                val_reg[s] <= val_next[s];
            end
        end
    end

    assign zip_stall = !ready[0];
    assign dig_valid = valid_reg[2];
    assign dig.err   = err_reg[2];
    assign dig.bcd   = val_reg[2][DAB_W-1:ZIP_W];

endmodule
`default_nettype wire

@@ rtl/zbe_check_enc.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// zbe_check_enc
// Pipeline stage that forms the check digit and maps all six digits to their
// two-of-five bar patterns, or clears the bars for an out-of-range code.
// ----------------------------------------------------------------------------
module zbe_check_enc
    import zbe_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        dig_valid,
    output logic             dig_stall,
    input  wire zbe_digits_t dig,
    output logic             bars_valid,
    input  wire logic        bars_stall,
    output zbe_bars_t        bars
);

    logic             valid_reg;
    zbe_bars_t        bars_reg;
    zbe_bars_t        bars_next;
    logic             ready;
    logic [6:0]       sum;
    logic [6:0]       rem;
    logic [DIGIT_W-1:0] chk;

    always_comb
    begin
        sum = 7'd0;
        for (int j = 0; j < DIGITS; j++)
        begin
            sum = sum + 7'(dig.bcd[DIGIT_W*j +: DIGIT_W]);
        end
        rem = sum;
        if (rem >= 7'd40)
        begin
            rem = rem - 7'd40;
        end
        if (rem >= 7'd20)
        begin
            rem = rem - 7'd20;
        end
        if (rem >= 7'd10)
        begin
            rem = rem - 7'd10;
        end
        chk = (rem == 7'd0) ? 4'd0 : DIGIT_W'(7'd10 - rem);
        bars_next.err = dig.err;
        for (int j = 0; j < DIGITS; j++)
        begin
            bars_next.bars[BARS_PER_DIGIT*(j+1) +: BARS_PER_DIGIT] =
                bar_code(dig.bcd[DIGIT_W*j +: DIGIT_W]);
        end
        bars_next.bars[BARS_PER_DIGIT-1:0] = bar_code(chk);
        if (dig.err)
        begin
            bars_next.bars = '0;
        end
    end

    assign ready = !valid_reg || !bars_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= dig_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && dig_valid)
        begin
            bars_reg <= bars_next;
        end
    end

    assign dig_stall  = !ready;
    assign bars_valid = valid_reg;
    assign bars       = bars_reg;

endmodule
`default_nettype wire

@@ rtl/zbe_serializer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// zbe_serializer
// Output stage that shifts the thirty bars out one per transfer, or emits the
// single range error result.
// ----------------------------------------------------------------------------
module zbe_serializer
    import zbe_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      bars_valid,
    output logic           bars_stall,
    input  wire zbe_bars_t bars,
    output logic           bar_valid,
    input  wire logic      bar_stall,
    output logic           full_bar,
    output logic           last_bar,
    output logic           range_error
);

    logic             valid_reg;
    logic             err_reg;
    logic [BAR_W-1:0] shift_reg;
    logic [CNT_W-1:0] count_reg;
    logic             last;
    logic             xfer;
    logic             load;

    assign last = err_reg || (count_reg == LAST_CNT);
    assign xfer = valid_reg && !bar_stall;
    assign load = bars_valid && (!valid_reg || (xfer && last));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            count_reg <= '0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            count_reg <= '0;
        end
        else if (xfer)
        begin
            if (last)
            begin
                valid_reg <= 1'b0;
                count_reg <= '0;
            end
            else
            begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            err_reg   <= bars.err;
            shift_reg <= bars.bars;
        end
        else if (xfer)
        begin
            shift_reg <= shift_reg << 1;
        end
    end

    assign bars_stall  = !(!valid_reg || (xfer && last));
    assign bar_valid   = valid_reg;
    assign full_bar    = shift_reg[BAR_W-1];
    assign last_bar    = last;
    assign range_error = err_reg;

    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && err_reg) |-> (count_reg == '0))
        else $error("range error result not at first slot");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= LAST_CNT)
        else $error("bar counter out of range");

    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (xfer && !last) |=> (valid_reg && count_reg == $past(count_reg) + 1'b1))
        else $error("bar sequence did not advance");

    a_err_bars: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && err_reg) |-> !full_bar)
        else $error("range error result carries a bar");

endmodule
`default_nettype wire

@@ rtl/postnet_zip_barcode_encoder.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// postnet_zip_barcode_encoder
// POSTNET encoder for a five-digit ZIP code with check digit, no frame bars.
// ----------------------------------------------------------------------------
// A ZIP code of 99999 or less produces 30 result transfers, one bar per
// cycle while bar_stall is low, most significant digit first and the check
// digit last; a larger code produces one result with range_error and
// last_bar set. The output shifter, emitting one bar per cycle while not
// stalled, sets the sustained rate of codes; a code passes through four
// pipeline stages (three binary-to-BCD stages and the check and encode stage)
// before its first bar appears, and the pipeline keeps accepting codes while
// bars are being shifted out, until its stages fill.
module postnet_zip_barcode_encoder
    import zbe_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             zip_valid,
    output logic                  zip_stall,
    input  wire logic [ZIP_W-1:0] zip_code,
    output logic                  bar_valid,
    input  wire logic             bar_stall,
    output logic                  full_bar,
    output logic                  last_bar,
    output logic                  range_error
);

    logic        dig_valid;
    logic        dig_stall;
    zbe_digits_t dig;
    logic        bars_valid;
    logic        bars_stall;
    zbe_bars_t   bars;

    zbe_bcd_conv u_bcd_conv (
        .clk       (clk),
        .rst_n     (rst_n),
        .zip_valid (zip_valid),
        .zip_stall (zip_stall),
        .zip_code  (zip_code),
        .dig_valid (dig_valid),
        .dig_stall (dig_stall),
        .dig       (dig)
    );

    zbe_check_enc u_check_enc (
        .clk        (clk),
        .rst_n      (rst_n),
        .dig_valid  (dig_valid),
        .dig_stall  (dig_stall),
        .dig        (dig),
        .bars_valid (bars_valid),
        .bars_stall (bars_stall),
        .bars       (bars)
    );

    zbe_serializer u_serializer (
        .clk         (clk),
        .rst_n       (rst_n),
        .bars_valid  (bars_valid),
        .bars_stall  (bars_stall),
        .bars        (bars),
        .bar_valid   (bar_valid),
        .bar_stall   (bar_stall),
        .full_bar    (full_bar),
        .last_bar    (last_bar),
        .range_error (range_error)
    );

endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the POSTNET ZIP code encoder. A driver feeds
// ZIP codes from a queue and a monitor predicts the bars of every accepted
// code and compares each bar transfer with the oldest expected bar. The run
// covers directed edge cases, a long output hold that backs up the input,
// random traffic with bursts of idle cycles on both sides, and a final part
// without idle cycles.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import zbe_pkg::*;

    localparam int unsigned ZIP_MAX    = 99999;
    localparam int          SETTLE     = 20;
    localparam int          LONG_HOLD  = 300;
    localparam int          QUIET_MAX  = 3000;
    localparam int          PRINT_MAX  = 100;
    localparam logic [4:0]  TWO_OF_FIVE [10] = '{
        5'b11000, 5'b00011, 5'b00101, 5'b00110, 5'b01001,
        5'b01010, 5'b01100, 5'b10001, 5'b10010, 5'b10100
    };

    typedef struct {
        logic full;
        logic last;
        logic err;
    } bar_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             zip_valid = 1'b0;
    logic             zip_stall;
    logic [ZIP_W-1:0] zip_code = '0;
    logic             bar_valid;
    logic             bar_stall = 1'b0;
    logic             full_bar;
    logic             last_bar;
    logic             range_error;

    logic [ZIP_W-1:0] zip_pending_q [$];
    bar_t             bar_expect_q [$];
    logic             zip_taken = 1'b0;
    logic             idle_on = 1'b0;
    int               send_gap = 0;
    int               stall_left = 0;
    int               hold_req = 0;
    int               hold_ack = 0;
    int               quiet_cycles = 0;
    int               error_count = 0;

    postnet_zip_barcode_encoder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .zip_valid   (zip_valid),
        .zip_stall   (zip_stall),
        .zip_code    (zip_code),
        .bar_valid   (bar_valid),
        .bar_stall   (bar_stall),
        .full_bar    (full_bar),
        .last_bar    (last_bar),
        .range_error (range_error)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string what);
        if (error_count < PRINT_MAX)
            $display("%0t ns: mismatch: %s", $time, what);
        error_count++;
    endtask

    // Expands one ZIP code into the bars it must produce, in order.
    function automatic void predict_bars(input logic [ZIP_W-1:0] zip);
        int unsigned value;
        int unsigned sum;
        int unsigned digit [6];
        bar_t        r;
        value = zip;
        sum = 0;
        if (value > ZIP_MAX) begin
            r.full = 1'b0;
            r.last = 1'b1;
            r.err  = 1'b1;
            bar_expect_q.push_back(r);
            return;
        end
        for (int d = 4; d >= 0; d--) begin
            digit[d] = value % 10;
            sum += digit[d];
            value /= 10;
        end
        digit[5] = (10 - sum % 10) % 10;
        for (int d = 0; d < 6; d++) begin
            for (int b = 0; b < 5; b++) begin
                r.full = TWO_OF_FIVE[digit[d]][4 - b];
                r.last = (d == 5) && (b == 4);
                r.err  = 1'b0;
                bar_expect_q.push_back(r);
            end
        end
    endfunction

    task automatic check_bar();
        bar_t e;
        if (bar_expect_q.size() == 0) begin
            report_mismatch("bar transfer with nothing expected");
            return;
        end
        e = bar_expect_q.pop_front();
        if (full_bar !== e.full)
            report_mismatch($sformatf("full_bar %b, expected %b", full_bar, e.full));
        if (last_bar !== e.last)
            report_mismatch($sformatf("last_bar %b, expected %b", last_bar, e.last));
        if (range_error !== e.err)
            report_mismatch($sformatf("range_error %b, expected %b", range_error, e.err));
    endtask

    always @(posedge clk) begin
        logic bar_taken;
        zip_taken = rst_n && zip_valid && !zip_stall;
        bar_taken = rst_n && bar_valid && !bar_stall;
        if (zip_taken)
            predict_bars(zip_code);
        if (bar_taken)
            check_bar();
        if (zip_taken || bar_taken)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_MAX) begin
            $display("tb_top failed");
            $finish;
        end
    end

    always @(negedge clk) begin
        if (rst_n && (!zip_valid || zip_taken)) begin
            if (send_gap > 0) begin
                zip_valid <= 1'b0;
                send_gap--;
            end else if (zip_pending_q.size() > 0) begin
                zip_valid <= 1'b1;
                zip_code  <= zip_pending_q.pop_front();
                if (idle_on && $urandom_range(0, 3) == 0)
                    send_gap = $urandom_range(1, 11);
            end else begin
                zip_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk) begin
        if (hold_req != hold_ack) begin
            hold_ack = hold_req;
            stall_left = LONG_HOLD;
        end
        if (stall_left > 0) begin
            bar_stall <= 1'b1;
            stall_left--;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            bar_stall <= 1'b1;
            stall_left = $urandom_range(0, 10);
        end else begin
            bar_stall <= 1'b0;
        end
    end

    task automatic drain();
        while (zip_pending_q.size() != 0 || zip_valid || bar_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic push_random(input int count);
        int unsigned z;
        int unsigned s;
        int unsigned t;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 7))
                0: z = $urandom_range(ZIP_MAX + 1, (1 << ZIP_W) - 1);
                1: begin
                    // Draw until the digit sum is a multiple of ten.
                    do begin
                        z = $urandom_range(0, ZIP_MAX);
                        s = 0;
                        t = z;
                        repeat (5) begin
                            s += t % 10;
                            t /= 10;
                        end
                    end while (s % 10 != 0);
                end
                default: z = $urandom_range(0, ZIP_MAX);
            endcase
            zip_pending_q.push_back(ZIP_W'(z));
        end
    endtask

    initial begin
        idle_on = 1'b1;
        foreach (TWO_OF_FIVE[i]) begin
        end
        zip_pending_q = '{
            17'd0, 17'd99999, 17'd100000, 17'd131071, 17'd65536,
            17'd12345, 17'd67890, 17'd19, 17'd55000, 17'd99991,
            17'd98765, 17'd24680, 17'd13579, 17'd11111, 17'd10000,
            17'd120000, 17'd100001, 17'd88888, 17'd70030, 17'd43210
        };
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        drain();

        // Hold the output long enough for the encoder to back up its input.
        hold_req++;
        push_random(12);
        drain();

        push_random(150);
        drain();

        idle_on = 1'b0;
        push_random(30);
        drain();

        if (bar_expect_q.size() != 0)
            report_mismatch("expected bars left over at the end");
        if (error_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
